// ===== rtl/ttb_pkg.sv =====
// shared types and constants of the tile triangle binner
package ttb_pkg;

  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned EDGES       = 3;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned DIV_STEPS   = 16;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [3:0] CORNER_ALL_OUT = 4'hf;

  localparam logic KIND_HIT     = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TILE_SIZE_LOG2 = 2'd0,
    CFG_TILE_STRIDE    = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic                  first;
    logic                  last;
    logic [3:0]            level;
    logic [31:0]           origin_x;
    logic [31:0]           origin_y;
    logic [EDGES-1:0][31:0] a;
    logic [EDGES-1:0][31:0] b;
    logic [EDGES-1:0][31:0] c;
  } ttb_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ttb_qstat_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_DIV,
    FE_PUSH
  } fe_state_e;

  typedef enum logic [1:0] {
    BE_IDLE,
    BE_EVAL,
    BE_HIT,
    BE_SUM
  } be_state_e;

endpackage

// ===== rtl/ttb_front.sv =====
// front end: config registers, item intake and tile index division
module ttb_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ttb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [15:0]                     cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            first_i,
  input  logic                            last_i,
  input  logic [15:0]                     tile_index_i,
  input  logic [ttb_pkg::EDGES-1:0][31:0] edge_a_i,
  input  logic [ttb_pkg::EDGES-1:0][31:0] edge_b_i,
  input  logic [ttb_pkg::EDGES-1:0][31:0] edge_c_i,
  input  ttb_pkg::ttb_qstat_t             qstat_i,
  output logic                            push_o,
  output ttb_pkg::ttb_item_t              item_o
);
  import ttb_pkg::*;

  fe_state_e            state_q, state_d;
  logic [3:0]           size_log2_q;
  logic [15:0]          stride_q;
  ttb_item_t            hold_q;
  logic [16:0]          rem_q, rem_d;
  logic [15:0]          quo_q, quo_d;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [16:0]          rem_sh;
  logic                 ge;
  logic                 accept;
  logic                 start_div;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_log2_q <= 4'd0;
      stride_q    <= 16'd1;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_TILE_SIZE_LOG2) begin
        size_log2_q <= cfg_data_i[3:0];
      end else if (cfg_index_i == CFG_TILE_STRIDE) begin
        stride_q <= cfg_data_i;
      end
    end
  end

  // outputs
  always_comb begin
    in_stall_o = 1'b1;
    push_o     = 1'b0;
    unique case (state_q)
      FE_IDLE: begin
        in_stall_o = 1'b0;
      end
      FE_PUSH: begin
        in_stall_o = qstat_i.full;
        push_o     = !qstat_i.full;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  assign accept    = in_valid_i && !in_stall_o;
  assign start_div = first_i && (stride_q != 16'd0);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FE_IDLE: begin
        if (in_valid_i) begin
          state_d = start_div ? FE_DIV : FE_PUSH;
        end
      end
      FE_DIV: begin
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_d = FE_PUSH;
        end
      end
      FE_PUSH: begin
        if (!qstat_i.full) begin
          if (in_valid_i) begin
            state_d = start_div ? FE_DIV : FE_PUSH;
          end else begin
            state_d = FE_IDLE;
          end
        end
      end
      default: begin
        state_d = FE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FE_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        cnt_q <= '0;
      end else if (state_q == FE_DIV) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_q[15:0], quo_q[15]};
    ge     = rem_sh >= {1'b0, stride_q};
    rem_d  = ge ? (rem_sh - {1'b0, stride_q}) : rem_sh;
    quo_d  = {quo_q[14:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hold_q.first    <= first_i;
      hold_q.last     <= last_i;
      hold_q.level    <= size_log2_q;
      hold_q.origin_x <= '0;
      hold_q.origin_y <= '0;
      hold_q.a        <= edge_a_i;
      hold_q.b        <= edge_b_i;
      hold_q.c        <= edge_c_i;
      if (start_div) begin
        rem_q <= '0;
        quo_q <= tile_index_i;
      end else begin
        rem_q <= {1'b0, tile_index_i};
        quo_q <= '0;
      end
    end else if (state_q == FE_DIV) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  always_comb begin
    item_o          = hold_q;
    item_o.origin_x = 32'(rem_q[15:0]) << hold_q.level;
    item_o.origin_y = 32'(quo_q) << hold_q.level;
  end

endmodule

// ===== rtl/ttb_queue.sv =====
// two-entry item queue between front and back end
module ttb_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ttb_pkg::ttb_item_t  item_i,
  input  logic                pop_i,
  output ttb_pkg::ttb_item_t  head_o,
  output ttb_pkg::ttb_qstat_t qstat_o
);
  import ttb_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  ttb_item_t        mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [PTR_W:0]   count_q;
  logic             do_push;
  logic             do_pop;

  assign qstat_o.full  = count_q == (PTR_W + 1)'(QUEUE_DEPTH);
  assign qstat_o.empty = count_q == '0;
  assign do_push       = push_i && !qstat_o.full;
  assign do_pop        = pop_i && !qstat_o.empty;
  assign head_o        = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== rtl/ttb_back.sv =====
// back end: edge tests at the tile corners, counters and result register
module ttb_back #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ttb_pkg::ttb_item_t  head_i,
  input  ttb_pkg::ttb_qstat_t qstat_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                kind_o,
  output logic [15:0]         prim_id_o,
  output logic [15:0]         tile_x_o,
  output logic [15:0]         tile_y_o,
  output logic [15:0]         hit_count_o,
  output logic [3:0]          level_o,
  output logic                end_of_run_o
);
  import ttb_pkg::*;

  be_state_e             state_q, state_d;
  logic [31:0]           org_x_q, org_y_q;
  logic [3:0]            level_q;
  logic [COUNT_BITS-1:0] prim_q, hit_q;
  logic [1:0]            step_q;
  logic [31:0]           pa_q, pb_q, pc_q, as_q, bs_q;
  logic                  reject_q;
  logic                  out_valid_q;
  logic [31:0]           ea, eb, ec;
  logic [31:0]           base, v1, v2, v3;
  logic                  edge_out;
  logic                  reject_now;
  logic                  out_free;
  logic                  latch, prim_inc, hit_inc, load_hit, load_sum;
  logic [31:0]           prim_ext, hit_ext;

  assign out_free = !out_valid_q || !out_stall_i;

  // edge picked for the multiply step
  always_comb begin
    unique case (step_q)
      2'd1: begin
        ea = head_i.a[1];
        eb = head_i.b[1];
        ec = head_i.c[1];
      end
      2'd2: begin
        ea = head_i.a[2];
        eb = head_i.b[2];
        ec = head_i.c[2];
      end
      default: begin
        ea = head_i.a[0];
        eb = head_i.b[0];
        ec = head_i.c[0];
      end
    endcase
  end

  // corner values of the previous edge
  always_comb begin
    base     = pa_q + pb_q + pc_q;
    v1       = base + as_q;
    v2       = base + bs_q;
    v3       = v1 + bs_q;
    edge_out = {v3[31], v2[31], v1[31], base[31]} == CORNER_ALL_OUT;
    reject_now = reject_q || ((step_q != 2'd0) && edge_out);
  end

  // outputs
  always_comb begin
    latch    = 1'b0;
    prim_inc = 1'b0;
    hit_inc  = 1'b0;
    load_hit = 1'b0;
    load_sum = 1'b0;
    pop_o    = 1'b0;
    unique case (state_q)
      BE_IDLE: begin
        latch = !qstat_i.empty;
      end
      BE_EVAL: begin
        if (step_q == 2'd3 && reject_now) begin
          prim_inc = 1'b1;
          pop_o    = !head_i.last;
        end
      end
      BE_HIT: begin
        if (out_free) begin
          load_hit = 1'b1;
          prim_inc = 1'b1;
          hit_inc  = 1'b1;
          pop_o    = !head_i.last;
        end
      end
      BE_SUM: begin
        if (out_free) begin
          load_sum = 1'b1;
          pop_o    = 1'b1;
        end
      end
      default: begin
        latch = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BE_IDLE: begin
        if (!qstat_i.empty) begin
          state_d = BE_EVAL;
        end
      end
      BE_EVAL: begin
        if (step_q == 2'd3) begin
          if (!reject_now) begin
            state_d = BE_HIT;
          end else if (head_i.last) begin
            state_d = BE_SUM;
          end else begin
            state_d = BE_IDLE;
          end
        end
      end
      BE_HIT: begin
        if (out_free) begin
          state_d = head_i.last ? BE_SUM : BE_IDLE;
        end
      end
      BE_SUM: begin
        if (out_free) begin
          state_d = BE_IDLE;
        end
      end
      default: begin
        state_d = BE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BE_IDLE;
      org_x_q     <= '0;
      org_y_q     <= '0;
      level_q     <= '0;
      prim_q      <= '0;
      hit_q       <= '0;
      step_q      <= '0;
      reject_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (latch) begin
        step_q   <= '0;
        reject_q <= 1'b0;
      end else if (state_q == BE_EVAL) begin
        step_q   <= step_q + 1'b1;
        reject_q <= reject_now;
      end
      if (latch && head_i.first) begin
        org_x_q <= head_i.origin_x;
        org_y_q <= head_i.origin_y;
        level_q <= head_i.level;
      end
      if ((latch && head_i.first) || load_sum) begin
        prim_q <= '0;
        hit_q  <= '0;
      end else begin
        if (prim_inc) begin
          prim_q <= prim_q + 1'b1;
        end
        if (hit_inc && (hit_q != '1)) begin
          hit_q <= hit_q + 1'b1;
        end
      end
      if (load_hit || load_sum) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // shared multiplier pair, one edge per cycle
  always_ff @(posedge clk_i) begin
    if (state_q == BE_EVAL && step_q != 2'd3) begin
      pa_q <= ea * org_x_q;
      pb_q <= eb * org_y_q;
      pc_q <= ec;
      as_q <= ea << level_q;
      bs_q <= eb << level_q;
    end
  end

  assign prim_ext = 32'(prim_q);
  assign hit_ext  = 32'(hit_q);

  always_ff @(posedge clk_i) begin
    if (load_hit) begin
      kind_o       <= KIND_HIT;
      prim_id_o    <= prim_ext[15:0];
      tile_x_o     <= '0;
      tile_y_o     <= '0;
      hit_count_o  <= '0;
      level_o      <= '0;
      end_of_run_o <= 1'b0;
    end else if (load_sum) begin
      kind_o       <= KIND_SUMMARY;
      prim_id_o    <= '0;
      tile_x_o     <= org_x_q[15:0];
      tile_y_o     <= org_y_q[15:0];
      hit_count_o  <= (hit_ext > 32'h0000_ffff) ? 16'hffff : hit_ext[15:0];
      level_o      <= level_q;
      end_of_run_o <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/tile_triangle_binner.sv =====
// top level of the tile triangle binner
// flow: the back end latches the queue head, runs its edge loop and then loads the
//   result register for a hit; with tile_stride not 0 an item marked first also passes the divider
// the back end takes a new item only once the last one is done, and a summary follows the
//   last item of a run; an item marked first holds the input while the divider runs
// reset: tile_size_log2 0, tile_stride 1, origin, level and counters 0, queue empty
module tile_triangle_binner #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ttb_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [15:0]                         cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                first_i,
  input  logic                                last_i,
  input  logic [15:0]                         tile_index_i,
  input  logic signed [31:0]                  edge0_a_i,
  input  logic signed [31:0]                  edge0_b_i,
  input  logic signed [31:0]                  edge0_c_i,
  input  logic signed [31:0]                  edge1_a_i,
  input  logic signed [31:0]                  edge1_b_i,
  input  logic signed [31:0]                  edge1_c_i,
  input  logic signed [31:0]                  edge2_a_i,
  input  logic signed [31:0]                  edge2_b_i,
  input  logic signed [31:0]                  edge2_c_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                kind_o,
  output logic [15:0]                         prim_id_o,
  output logic [15:0]                         tile_x_o,
  output logic [15:0]                         tile_y_o,
  output logic [15:0]                         hit_count_o,
  output logic [3:0]                          level_o,
  output logic                                end_of_run_o
);
  import ttb_pkg::*;

  logic [EDGES-1:0][31:0] edge_a, edge_b, edge_c;
  ttb_item_t              push_item;
  ttb_item_t              head;
  ttb_qstat_t             qstat;
  logic                   push;
  logic                   pop;

  assign edge_a = {edge2_a_i, edge1_a_i, edge0_a_i};
  assign edge_b = {edge2_b_i, edge1_b_i, edge0_b_i};
  assign edge_c = {edge2_c_i, edge1_c_i, edge0_c_i};

  ttb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .first_i      (first_i),
    .last_i       (last_i),
    .tile_index_i (tile_index_i),
    .edge_a_i     (edge_a),
    .edge_b_i     (edge_b),
    .edge_c_i     (edge_c),
    .qstat_i      (qstat),
    .push_o       (push),
    .item_o       (push_item)
  );

  ttb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .head_o  (head),
    .qstat_o (qstat)
  );

  ttb_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .qstat_i      (qstat),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .prim_id_o    (prim_id_o),
    .tile_x_o     (tile_x_o),
    .tile_y_o     (tile_y_o),
    .hit_count_o  (hit_count_o),
    .level_o      (level_o),
    .end_of_run_o (end_of_run_o)
  );

endmodule

// ===== tb/tile_triangle_binner_tb.sv =====
// self-checking testbench of the tile triangle binner with its own binning predictor
`timescale 1ns / 100ps

module tile_triangle_binner_tb;
  import ttb_pkg::*;

  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 200;
  localparam int QUIET_LIMIT  = 5000;
  localparam int MAX_REPORTS  = 10;
  localparam int LONG_RUN     = 40;
  localparam int PHASE_ITEMS  = 150;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic             first;
    logic             last;
    logic [15:0]      tile_index;
    logic [2:0][31:0] a;
    logic [2:0][31:0] b;
    logic [2:0][31:0] c;
  } prim_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] prim_id;
    logic [15:0] tile_x;
    logic [15:0] tile_y;
    logic [15:0] hit_count;
    logic [3:0]  level;
    logic        end_of_run;
  } bin_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        first_i = 1'b0;
  logic        last_i = 1'b0;
  logic [15:0] tile_index_i = '0;
  logic [31:0] edge0_a_i = '0, edge0_b_i = '0, edge0_c_i = '0;
  logic [31:0] edge1_a_i = '0, edge1_b_i = '0, edge1_c_i = '0;
  logic [31:0] edge2_a_i = '0, edge2_b_i = '0, edge2_c_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        kind_o;
  logic [15:0] prim_id_o, tile_x_o, tile_y_o, hit_count_o;
  logic [3:0]  level_o;
  logic        end_of_run_o;

  // predictor copy of registers and run state
  logic [3:0]  size_log2_q = '0;
  logic [15:0] stride_q = 16'd1;
  logic [31:0] org_x = '0;
  logic [31:0] org_y = '0;
  logic [15:0] prim_pos = '0;
  logic [15:0] hit_total = '0;
  logic [3:0]  run_level = '0;

  prim_t       prims_pending[$];
  bin_result_t bins_expected[$];
  prim_t       cur_prim;
  bin_result_t seen_bin, due_bin;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  logic        hold_on = 1'b0;
  int          errors = 0;
  int          quiet_cycles = 0;

  tile_triangle_binner uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .first_i      (first_i),
    .last_i       (last_i),
    .tile_index_i (tile_index_i),
    .edge0_a_i    (edge0_a_i),
    .edge0_b_i    (edge0_b_i),
    .edge0_c_i    (edge0_c_i),
    .edge1_a_i    (edge1_a_i),
    .edge1_b_i    (edge1_b_i),
    .edge1_c_i    (edge1_c_i),
    .edge2_a_i    (edge2_a_i),
    .edge2_b_i    (edge2_b_i),
    .edge2_c_i    (edge2_c_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .prim_id_o    (prim_id_o),
    .tile_x_o     (tile_x_o),
    .tile_y_o     (tile_y_o),
    .hit_count_o  (hit_count_o),
    .level_o      (level_o),
    .end_of_run_o (end_of_run_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // edge is outside when all four corner samples are negative
  function automatic logic edge_rejects(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    logic [31:0] step, x, y, v;
    int          k, neg;
    neg = 0;
    step = 32'd1 << run_level;
    for (k = 0; k < 4; k++) begin
      x = org_x + (((k & 1) != 0) ? step : 32'd0);
      y = org_y + (((k & 2) != 0) ? step : 32'd0);
      v = a * x + b * y + c;
      if (v[31]) neg++;
    end
    return neg == 4;
  endfunction

  function automatic void bin_primitive(prim_t p);
    logic [15:0] col, row;
    logic        hit;
    bin_result_t r;
    int          e;
    if (p.first) begin
      if (stride_q == 16'd0) begin
        col = p.tile_index;
        row = '0;
      end else begin
        col = p.tile_index % stride_q;
        row = p.tile_index / stride_q;
      end
      run_level = size_log2_q;
      org_x = {16'd0, col} << run_level;
      org_y = {16'd0, row} << run_level;
      prim_pos = '0;
      hit_total = '0;
    end
    hit = 1'b1;
    for (e = 0; e < 3; e++) begin
      if (edge_rejects(p.a[e], p.b[e], p.c[e])) hit = 1'b0;
    end
    if (hit) begin
      r = '0;
      r.kind = KIND_HIT;
      r.prim_id = prim_pos;
      bins_expected.push_back(r);
      if (hit_total != 16'hffff) hit_total++;
    end
    prim_pos++;
    if (p.last) begin
      r = '0;
      r.kind = KIND_SUMMARY;
      r.tile_x = org_x[15:0];
      r.tile_y = org_y[15:0];
      r.hit_count = hit_total;
      r.level = run_level;
      r.end_of_run = 1'b1;
      bins_expected.push_back(r);
      prim_pos = '0;
      hit_total = '0;
    end
  endfunction

  function automatic logic [31:0] pick_coef();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0, 1: v = $urandom;
      2, 3: v = $urandom_range(0, 512) - 256;
      4: begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = 32'hffff_ffff;
          default: v = 32'h0000_0000;
        endcase
      end
      default: v = $urandom_range(0, 32'h000f_ffff) - 32'h0008_0000;
    endcase
    return v;
  endfunction

  function automatic prim_t make_prim(logic first, logic last);
    prim_t p;
    int    e, cut;
    p.first = first;
    p.last = last;
    case ($urandom_range(0, 3))
      0: p.tile_index = 16'($urandom_range(0, 15));
      1: p.tile_index = ($urandom_range(0, 1) != 0) ? 16'hffff : 16'h0000;
      default: p.tile_index = 16'($urandom_range(0, 16'hffff));
    endcase
    for (e = 0; e < 3; e++) begin
      p.a[e] = pick_coef();
      p.b[e] = pick_coef();
      p.c[e] = pick_coef();
    end
    // one edge plainly outside everywhere
    if ($urandom_range(0, 3) == 0) begin
      cut = $urandom_range(0, 2);
      p.a[cut] = '0;
      p.b[cut] = '0;
      p.c[cut] = $urandom | 32'h8000_0000;
    end
    return p;
  endfunction

  function automatic prim_t flat_prim(logic first, logic last, logic [15:0] idx,
                                      logic [31:0] c0, logic [31:0] c1, logic [31:0] c2);
    prim_t p;
    p = '0;
    p.first = first;
    p.last = last;
    p.tile_index = idx;
    p.c[0] = c0;
    p.c[1] = c1;
    p.c[2] = c2;
    return p;
  endfunction

  // mostly complete tile runs, some stray first and last flags
  task automatic queue_runs(int n);
    int left, len, k;
    left = n;
    while (left > 0) begin
      if ($urandom_range(0, 4) != 0) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        for (k = 0; k < len; k++) prims_pending.push_back(make_prim(k == 0, k == len - 1));
        left -= len;
      end else begin
        prims_pending.push_back(make_prim(1'($urandom_range(0, 1)),
                                          1'($urandom_range(0, 1))));
        left--;
      end
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_TILE_SIZE_LOG2: size_log2_q = data[3:0];
      CFG_TILE_STRIDE:    stride_q = data;
      default: ;
    endcase
  endtask

  task automatic set_tiling(logic [3:0] level, logic [15:0] stride);
    logic [11:0] junk;
    junk = 12'($urandom_range(0, 12'hfff));
    write_reg(CFG_TILE_SIZE_LOG2, {junk, level});
    write_reg(CFG_TILE_STRIDE, stride);
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (prims_pending.size() != 0 || in_valid_i || bins_expected.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) bin_primitive(cur_prim);
      if (!in_valid_i || !in_stall_o) begin
        if (prims_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_prim = prims_pending.pop_front();
          first_i <= cur_prim.first;
          last_i <= cur_prim.last;
          tile_index_i <= cur_prim.tile_index;
          edge0_a_i <= cur_prim.a[0];
          edge0_b_i <= cur_prim.b[0];
          edge0_c_i <= cur_prim.c[0];
          edge1_a_i <= cur_prim.a[1];
          edge1_b_i <= cur_prim.b[1];
          edge1_c_i <= cur_prim.c[1];
          edge2_a_i <= cur_prim.a[2];
          edge2_b_i <= cur_prim.b[2];
          edge2_c_i <= cur_prim.c[2];
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        seen_bin = {kind_o, prim_id_o, tile_x_o, tile_y_o, hit_count_o, level_o,
                    end_of_run_o};
        if (bins_expected.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("unexpected item: kind %0d id %0d x %0d y %0d hits %0d lvl %0d eor %0d",
                     seen_bin.kind, seen_bin.prim_id, seen_bin.tile_x, seen_bin.tile_y,
                     seen_bin.hit_count, seen_bin.level, seen_bin.end_of_run);
        end else begin
          due_bin = bins_expected.pop_front();
          if (seen_bin !== due_bin) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
              $display("mismatch at %0t", $realtime);
              $display("  expected kind %0d id %0d x %0d y %0d hits %0d lvl %0d eor %0d",
                       due_bin.kind, due_bin.prim_id, due_bin.tile_x, due_bin.tile_y,
                       due_bin.hit_count, due_bin.level, due_bin.end_of_run);
              $display("  actual   kind %0d id %0d x %0d y %0d hits %0d lvl %0d eor %0d",
                       seen_bin.kind, seen_bin.prim_id, seen_bin.tile_x, seen_bin.tile_y,
                       seen_bin.hit_count, seen_bin.level, seen_bin.end_of_run);
            end
          end
        end
      end
      out_stall_i <= hold_on || ($urandom_range(0, 99) < stall_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("no item moved for %0d cycles", QUIET_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    prim_t d;
    int    i, p;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset tiling, no idling
    set_idling(0, 0);
    prims_pending.push_back(flat_prim(1'b0, 1'b0, 16'h1234, 32'd0, 32'd0, 32'd0));
    prims_pending.push_back(flat_prim(1'b0, 1'b1, 16'h0000, 32'hffff_ffff, 32'd0, 32'd0));
    prims_pending.push_back(flat_prim(1'b0, 1'b0, 16'h0000, 32'd0, 32'h8000_0000, 32'd0));
    prims_pending.push_back(flat_prim(1'b0, 1'b0, 16'h0000, 32'd0, 32'd0, 32'd0));
    d = flat_prim(1'b1, 1'b0, 16'hffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
    d.a = {32'h0000_0000, 32'h8000_0000, 32'h7fff_ffff};
    d.b = {32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000};
    prims_pending.push_back(d);
    prims_pending.push_back(flat_prim(1'b1, 1'b1, 16'h0000, 32'd0, 32'd0, 32'hffff_fff0));
    prims_pending.push_back(make_prim(1'b1, 1'b0));
    // leave a run open across the register writes
    prims_pending.push_back(flat_prim(1'b1, 1'b0, 16'd5, 32'd0, 32'd0, 32'd0));
    wait_drained();

    set_tiling(4'd15, 16'd0);
    write_reg(CFG_SPARE_LO, 16'($urandom_range(0, 16'hffff)));
    write_reg(CFG_SPARE_HI, 16'($urandom_range(0, 16'hffff)));
    prims_pending.push_back(flat_prim(1'b0, 1'b1, 16'h00ff, 32'd0, 32'd0, 32'd0));
    d = flat_prim(1'b1, 1'b0, 16'hffff, 32'd0, 32'd0, 32'd0);
    d.a[0] = 32'd1;
    prims_pending.push_back(d);
    d = flat_prim(1'b0, 1'b0, 16'h0000, 32'd0, 32'd0, 32'd0);
    d.a[0] = 32'hffff_ffff;
    prims_pending.push_back(d);
    d = flat_prim(1'b0, 1'b1, 16'h0000, 32'd0, 32'd0, 32'd0);
    d.b[1] = 32'd1;
    prims_pending.push_back(d);
    prims_pending.push_back(make_prim(1'b0, 1'b1));
    wait_drained();

    // one longer run where every primitive is a hit
    set_tiling(4'd2, 16'd300);
    for (i = 0; i < LONG_RUN; i++)
      prims_pending.push_back(flat_prim(i == 0, i == LONG_RUN - 1,
                                        16'($urandom_range(0, 16'hffff)), 32'd0, 32'd0,
                                        $urandom_range(0, 32'h7fff_ffff)));
    wait_drained();

    for (p = 0; p < 8; p++) begin
      case (p)
        0: set_tiling(4'd0, 16'd1);
        1: set_tiling(4'd15, 16'hffff);
        2: set_tiling(4'd15, 16'd1);
        3: set_tiling(4'd0, 16'd0);
        default: set_tiling(4'($urandom_range(0, 15)),
                            ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 4))
                                                         : 16'($urandom_range(0, 16'hffff)));
      endcase
      case (p % 4)
        0: set_idling(0, 0);
        1: set_idling(75, 0);
        2: set_idling(0, 75);
        default: set_idling(30, 30);
      endcase
      queue_runs(PHASE_ITEMS);
      if (p == 0) begin
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_on <= 1'b0;
      end
      wait_drained();
    end

    if (bins_expected.size() != 0) begin
      $display("%0d expected items never arrived", bins_expected.size());
      errors++;
    end
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== tile_triangle_binner.f =====
rtl/ttb_pkg.sv
rtl/ttb_front.sv
rtl/ttb_queue.sv
rtl/ttb_back.sv
rtl/tile_triangle_binner.sv
tb/tile_triangle_binner_tb.sv
